// ===== hdl/tpcsf_pkg.sv =====
// Shared widths, codes, types and helper functions of the current sense front end.
package tpcsf_pkg;

    localparam int ADC_BITS   = 12;
    localparam int DIFF_W     = ADC_BITS + 1;
    localparam int CUR_GAIN_W = 18;
    localparam int BUS_GAIN_W = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 16;
    localparam int SUM_W      = ADC_BITS + CNT_W;
    localparam int DIVISOR_W  = CNT_W + 1;
    localparam int STEP_W     = $clog2(ADC_BITS + 1);
    localparam int Q_FRAC     = 16;
    localparam int OUT_W      = 16;
    localparam int TOTAL_W    = 32;
    localparam int MUL_X_W    = DIFF_W;
    localparam int MUL_Y_W    = BUS_GAIN_W + 1;
    localparam int PROD_W     = MUL_X_W + MUL_Y_W;
    localparam int SHIFT_W    = PROD_W - Q_FRAC;

    localparam logic [ADC_BITS-1:0] RAIL_LOW_CODE  = ADC_BITS'(64);
    localparam logic [ADC_BITS-1:0] RAIL_HIGH_CODE = ADC_BITS'(4032);
    localparam logic [ADC_BITS-1:0] ZERO_RESET     = ADC_BITS'(1 << (ADC_BITS - 1));

    localparam logic [CUR_GAIN_W-1:0] CUR_GAIN_RESET    = CUR_GAIN_W'(105627);
    localparam logic [BUS_GAIN_W-1:0] BUS_GAIN_RESET    = BUS_GAIN_W'(580946);
    localparam logic [ADC_BITS-1:0]   BUS_MIN_RESET     = ADC_BITS'(200);
    localparam logic [ADC_BITS-1:0]   ZERO_MIN_RESET    = ADC_BITS'(1241);
    localparam logic [ADC_BITS-1:0]   ZERO_MAX_RESET    = ADC_BITS'(2854);
    localparam logic [CNT_W-1:0]      CAL_SAMPLES_RESET = CNT_W'(64);

    localparam logic signed [SHIFT_W-1:0] CUR_MAX = SHIFT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [SHIFT_W-1:0] CUR_MIN = SHIFT_W'(-(2 ** (OUT_W - 1)));
    localparam logic [SHIFT_W-1:0]        BUS_MAX = SHIFT_W'((2 ** OUT_W) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURRENT_GAIN = 3'd0,
        REG_BUS_GAIN     = 3'd1,
        REG_BUS_MIN      = 3'd2,
        REG_ZERO_MIN     = 3'd3,
        REG_ZERO_MAX     = 3'd4,
        REG_CAL_SAMPLES  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        CAL_NONE     = 2'd0,
        CAL_ACCEPTED = 2'd1,
        CAL_REJECTED = 2'd2
    } cal_stat_t;

    typedef enum logic [1:0] {
        MUL_A,
        MUL_B,
        MUL_BUS
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL_BUS,
        ST_FINISH,
        ST_DIV,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     capture;
        logic     prod_en;
        mul_sel_t mul_sel;
        logic     take_a;
        logic     take_b;
        logic     reject;
        logic     cal_acc;
        logic     judge;
        logic     out_load;
        logic     out_conv;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cmd_cal;
        logic bad;
        logic cal_complete;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // Clamp a floored Q16 product to the signed result range
    function automatic logic signed [OUT_W-1:0] sat_cur(input logic signed [SHIFT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > CUR_MAX) begin
            r = OUT_W'(CUR_MAX);
        end else if (v < CUR_MIN) begin
            r = OUT_W'(CUR_MIN);
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // Clamp an unsigned bus value to the result range
    function automatic logic [OUT_W-1:0] sat_bus(input logic [SHIFT_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > BUS_MAX) begin
            r = OUT_W'(BUS_MAX);
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic near_rail(input logic [ADC_BITS-1:0] c);
        return (c < RAIL_LOW_CODE) || (c > RAIL_HIGH_CODE);
    endfunction

endpackage

// ===== hdl/tpcsf_div.sv =====
// Restoring serial divider for the calibration average, one quotient bit a cycle.
module tpcsf_div
    import tpcsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [ADC_BITS-1:0]  quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [ADC_BITS-1:0]  shift_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 q_bit;

    // Bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, shift_reg[ADC_BITS-1]};
    assign q_bit = (trial >= {1'b0, divisor_reg});

    // Sequence the steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ADC_BITS);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the quotient in behind the dividend bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= DIVISOR_W'(dividend[SUM_W-1:ADC_BITS]);
            shift_reg   <= dividend[ADC_BITS-1:0];
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg   <= q_bit ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                               : trial[DIVISOR_W-1:0];
            shift_reg <= {shift_reg[ADC_BITS-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

// ===== hdl/tpcsf_ctrl.sv =====
// Controller state machine: sequences conversion, rejection and calibration of one item.
module tpcsf_ctrl
    import tpcsf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (stat.cmd_cal) begin
                    state_next = stat.cal_complete ? ST_DIV : ST_OUT;
                end else if (stat.bad) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MUL_BUS;
                end
            end
            ST_MUL_BUS: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_A;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                cmd.prod_en = s_valid;
                cmd.mul_sel = MUL_A;
            end
            ST_DISPATCH: begin
                priority if (stat.cmd_cal) begin
                    cmd.cal_acc = 1'b1;
                end else if (stat.bad) begin
                    cmd.reject = 1'b1;
                end else begin
                    cmd.take_a  = 1'b1;
                    cmd.prod_en = 1'b1;
                    cmd.mul_sel = MUL_B;
                end
            end
            ST_MUL_BUS: begin
                cmd.take_b  = 1'b1;
                cmd.prod_en = 1'b1;
                cmd.mul_sel = MUL_BUS;
            end
            ST_FINISH: begin
                cmd.out_load = stat.out_free;
                cmd.out_conv = 1'b1;
            end
            ST_DIV: begin
                cmd.judge = stat.div_done;
            end
            ST_OUT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/tpcsf_dp.sv =====
// Datapath: configuration, shared multiplier, counters, calibration sums and output register.
module tpcsf_dp
    import tpcsf_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_command,
    input  logic [ADC_BITS-1:0]       s_code_a,
    input  logic [ADC_BITS-1:0]       s_code_b,
    input  logic [ADC_BITS-1:0]       s_code_bus,
    input  logic                      m_ready,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    output logic                      m_valid,
    output logic                      m_sample_valid,
    output logic signed [OUT_W-1:0]   m_phase_a_ma,
    output logic signed [OUT_W-1:0]   m_phase_b_ma,
    output logic signed [OUT_W-1:0]   m_phase_c_ma,
    output logic [OUT_W-1:0]          m_bus_mv,
    output logic [TOTAL_W-1:0]        m_invalid_total,
    output logic [TOTAL_W-1:0]        m_rail_total,
    output logic                      m_calibrated,
    output logic [ADC_BITS-1:0]       m_zero_code_a,
    output logic [ADC_BITS-1:0]       m_zero_code_b,
    output logic [1:0]                m_cal_status
);

    // Configuration
    logic [CUR_GAIN_W-1:0] cur_gain_reg;
    logic [BUS_GAIN_W-1:0] bus_gain_reg;
    logic [ADC_BITS-1:0]   bus_min_reg;
    logic [ADC_BITS-1:0]   zero_min_reg;
    logic [ADC_BITS-1:0]   zero_max_reg;
    logic [CNT_W-1:0]      cal_samples_reg;

    // Captured item and working values
    logic                     cmd_reg;
    logic [ADC_BITS-1:0]      code_a_reg;
    logic [ADC_BITS-1:0]      code_b_reg;
    logic [ADC_BITS-1:0]      code_bus_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OUT_W-1:0]  ia_reg;
    logic signed [OUT_W-1:0]  ib_reg;

    // Persistent state
    logic [ADC_BITS-1:0] zero_a_reg;
    logic [ADC_BITS-1:0] zero_b_reg;
    logic                is_cal_reg;
    logic [SUM_W-1:0]    sum_a_reg;
    logic [SUM_W-1:0]    sum_b_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TOTAL_W-1:0]  invalid_reg;
    logic [TOTAL_W-1:0]  rail_reg;
    cal_stat_t           outcome_reg;

    // Output register
    logic m_valid_reg;

    logic signed [MUL_X_W-1:0] mul_x;
    logic signed [MUL_Y_W-1:0] mul_y;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SHIFT_W-1:0] prod_sh;
    logic signed [SHIFT_W-1:0] c_wide;
    logic [CNT_W-1:0]          count_inc;
    logic [CNT_W-1:0]          target;
    logic [SUM_W-1:0]          sum_a_inc;
    logic [SUM_W-1:0]          sum_b_inc;
    logic [DIVISOR_W-1:0]      divisor;
    logic                      div_start;
    logic                      done_a;
    logic                      done_b;
    logic [ADC_BITS-1:0]       avg_a;
    logic [ADC_BITS-1:0]       avg_b;
    logic                      zero_ok;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_gain_reg    <= CUR_GAIN_RESET;
            bus_gain_reg    <= BUS_GAIN_RESET;
            bus_min_reg     <= BUS_MIN_RESET;
            zero_min_reg    <= ZERO_MIN_RESET;
            zero_max_reg    <= ZERO_MAX_RESET;
            cal_samples_reg <= CAL_SAMPLES_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_CURRENT_GAIN: cur_gain_reg    <= cfg_wdata[CUR_GAIN_W-1:0];
                REG_BUS_GAIN:     bus_gain_reg    <= cfg_wdata[BUS_GAIN_W-1:0];
                REG_BUS_MIN:      bus_min_reg     <= cfg_wdata[ADC_BITS-1:0];
                REG_ZERO_MIN:     zero_min_reg    <= cfg_wdata[ADC_BITS-1:0];
                REG_ZERO_MAX:     zero_max_reg    <= cfg_wdata[ADC_BITS-1:0];
                REG_CAL_SAMPLES:  cal_samples_reg <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Select operands for the shared multiplier
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_A: begin
                mul_x = $signed({1'b0, s_code_a}) - $signed({1'b0, zero_a_reg});
                mul_y = $signed(MUL_Y_W'(cur_gain_reg));
            end
            MUL_B: begin
                mul_x = $signed({1'b0, code_b_reg}) - $signed({1'b0, zero_b_reg});
                mul_y = $signed(MUL_Y_W'(cur_gain_reg));
            end
            MUL_BUS: begin
                mul_x = $signed(MUL_X_W'(code_bus_reg));
                mul_y = $signed(MUL_Y_W'(bus_gain_reg));
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p   = mul_x * mul_y;
    assign prod_sh = prod_reg[PROD_W-1:Q_FRAC];
    assign c_wide  = -(SHIFT_W'(ia_reg) + SHIFT_W'(ib_reg));

    // Capture the item and hold the products
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg      <= s_command;
            code_a_reg   <= s_code_a;
            code_b_reg   <= s_code_b;
            code_bus_reg <= s_code_bus;
        end
        if (cmd.prod_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.take_a) begin
            ia_reg <= sat_cur(prod_sh);
        end
        if (cmd.take_b) begin
            ib_reg <= sat_cur(prod_sh);
        end
    end

    // Calibration run bookkeeping
    assign count_inc = count_reg + CNT_W'(1);
    assign target    = (cal_samples_reg == '0) ? CNT_W'(1) : cal_samples_reg;
    assign sum_a_inc = sum_a_reg + SUM_W'(code_a_reg);
    assign sum_b_inc = sum_b_reg + SUM_W'(code_b_reg);
    assign divisor   = {(count_inc == '0), count_inc};
    assign div_start = cmd.cal_acc && stat.cal_complete;
    assign zero_ok   = (avg_a >= zero_min_reg) && (avg_a <= zero_max_reg) &&
                       (avg_b >= zero_min_reg) && (avg_b <= zero_max_reg);

    tpcsf_div u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_a_inc),
        .divisor  (divisor),
        .done     (done_a),
        .quotient (avg_a)
    );

    tpcsf_div u_div_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_b_inc),
        .divisor  (divisor),
        .done     (done_b),
        .quotient (avg_b)
    );

    // Advance counters, sums and zero offsets
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_a_reg  <= ZERO_RESET;
            zero_b_reg  <= ZERO_RESET;
            is_cal_reg  <= 1'b0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            count_reg   <= '0;
            invalid_reg <= '0;
            rail_reg    <= '0;
            outcome_reg <= CAL_NONE;
        end else begin
            if (cmd.reject) begin
                invalid_reg <= invalid_reg + TOTAL_W'(1);
                if (near_rail(code_a_reg) || near_rail(code_b_reg)) begin
                    rail_reg <= rail_reg + TOTAL_W'(1);
                end
            end
            if (cmd.cal_acc) begin
                outcome_reg <= CAL_NONE;
                if (stat.cal_complete) begin
                    sum_a_reg <= '0;
                    sum_b_reg <= '0;
                    count_reg <= '0;
                end else begin
                    sum_a_reg <= sum_a_inc;
                    sum_b_reg <= sum_b_inc;
                    count_reg <= count_inc;
                end
            end
            if (cmd.judge) begin
                if (zero_ok) begin
                    zero_a_reg  <= avg_a;
                    zero_b_reg  <= avg_b;
                    is_cal_reg  <= 1'b1;
                    outcome_reg <= CAL_ACCEPTED;
                end else begin
                    is_cal_reg  <= 1'b0;
                    outcome_reg <= CAL_REJECTED;
                end
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_sample_valid  <= cmd.out_conv;
            m_phase_a_ma    <= cmd.out_conv ? ia_reg : '0;
            m_phase_b_ma    <= cmd.out_conv ? ib_reg : '0;
            m_phase_c_ma    <= cmd.out_conv ? sat_cur(c_wide) : '0;
            m_bus_mv        <= cmd.out_conv ? sat_bus(prod_reg[PROD_W-1:Q_FRAC]) : '0;
            m_invalid_total <= invalid_reg;
            m_rail_total    <= rail_reg;
            m_calibrated    <= is_cal_reg;
            m_zero_code_a   <= zero_a_reg;
            m_zero_code_b   <= zero_b_reg;
            m_cal_status    <= outcome_reg;
        end
    end

    // Report status to the controller
    assign stat.cmd_cal      = cmd_reg;
    assign stat.bad          = ((code_a_reg == '0) && (code_b_reg == '0) &&
                                (code_bus_reg == '0)) || (code_bus_reg < bus_min_reg);
    assign stat.cal_complete = (count_inc >= target) || (count_inc == '0);
    assign stat.div_done     = done_a && done_b;
    assign stat.out_free     = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/three_phase_current_sense_frontend.sv =====
// Top level of the two-shunt phase current front end: controller plus datapath.
//
// Each input item is one ADC scan (s_command, s_code_a, s_code_b, s_code_bus) on a
// valid/ready channel; each accepted item gives exactly one result item on the m_
// channel. Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata
// with no handshake; the user must write them only while the block is idle, as the block has no guard for it.
// Steps of an item from the accept to the load of the result register:
//   convert scan that passes plausibility: three passes through the one shared
//     multiplier, then phase C and bus saturation on the load
//   rejected convert scan or calibration scan that does not end a run: dispatch, load
//   calibration scan that ends a run: the 12-step serial divider forms the averaged
//     zero codes before the load
// After each load the block goes back to idle before it accepts the next item.
// One item is in work at a time; s_ready rises again just after the result loads.
// The result register lets the next item be taken while a result waits; a stalled
// receiver holds the finished result and the next item waits at its last step.
// Reset (aresetn low, synchronous) restores register defaults, zeros of mid-rail,
// cleared counters and sums, and drops m_valid.
module three_phase_current_sense_frontend
    import tpcsf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [ADC_BITS-1:0]     s_code_a,
    input  logic [ADC_BITS-1:0]     s_code_b,
    input  logic [ADC_BITS-1:0]     s_code_bus,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_sample_valid,
    output logic signed [OUT_W-1:0] m_phase_a_ma,
    output logic signed [OUT_W-1:0] m_phase_b_ma,
    output logic signed [OUT_W-1:0] m_phase_c_ma,
    output logic [OUT_W-1:0]        m_bus_mv,
    output logic [TOTAL_W-1:0]      m_invalid_total,
    output logic [TOTAL_W-1:0]      m_rail_total,
    output logic                    m_calibrated,
    output logic [ADC_BITS-1:0]     m_zero_code_a,
    output logic [ADC_BITS-1:0]     m_zero_code_b,
    output logic [1:0]              m_cal_status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tpcsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tpcsf_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_command       (s_command),
        .s_code_a        (s_code_a),
        .s_code_b        (s_code_b),
        .s_code_bus      (s_code_bus),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_sample_valid  (m_sample_valid),
        .m_phase_a_ma    (m_phase_a_ma),
        .m_phase_b_ma    (m_phase_b_ma),
        .m_phase_c_ma    (m_phase_c_ma),
        .m_bus_mv        (m_bus_mv),
        .m_invalid_total (m_invalid_total),
        .m_rail_total    (m_rail_total),
        .m_calibrated    (m_calibrated),
        .m_zero_code_a   (m_zero_code_a),
        .m_zero_code_b   (m_zero_code_b),
        .m_cal_status    (m_cal_status)
    );

endmodule

// ===== hdl/tpcsf_chk.sv =====
// Port-level checker for the current sense front end, bound to the top level.
module tpcsf_chk
    import tpcsf_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_sample_valid,
    input logic signed [OUT_W-1:0] m_phase_a_ma,
    input logic signed [OUT_W-1:0] m_phase_b_ma,
    input logic signed [OUT_W-1:0] m_phase_c_ma,
    input logic [OUT_W-1:0]        m_bus_mv,
    input logic [TOTAL_W-1:0]      m_invalid_total,
    input logic [1:0]              m_cal_status
);

    // No result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One item in work at a time: input closes after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");

    // Phase currents of a valid sample sum to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sample_valid) |->
        (OUT_W'(m_phase_a_ma + m_phase_b_ma + m_phase_c_ma) == '0))
        else $error("phase currents do not sum to zero");

    // Rejected and calibration items carry zeroed measurements
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sample_valid) |->
        (m_phase_a_ma == '0 && m_phase_b_ma == '0 && m_phase_c_ma == '0 && m_bus_mv == '0))
        else $error("measurements not cleared on a non-sample item");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_invalid_total) &&
        $stable(m_phase_a_ma) && $stable(m_cal_status)))
        else $error("stalled result changed");

endmodule

bind three_phase_current_sense_frontend tpcsf_chk u_tpcsf_chk (.*);

// ===== tb/three_phase_current_sense_frontend_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-shunt phase current front end, with its own predictor.
module three_phase_current_sense_frontend_tb;
    import tpcsf_pkg::*;

    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;
    localparam int   IDLE_PCT      = 38;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   QUIET_LIMIT   = 4000;
    localparam int   TAIL_CYCLES   = 24;
    localparam int   REPORT_MAX    = 10;

    typedef struct {
        logic                    sample_valid;
        logic signed [OUT_W-1:0] phase_a;
        logic signed [OUT_W-1:0] phase_b;
        logic signed [OUT_W-1:0] phase_c;
        logic [OUT_W-1:0]        bus_mv;
        logic [TOTAL_W-1:0]      invalid_total;
        logic [TOTAL_W-1:0]      rail_total;
        logic                    calibrated;
        logic [ADC_BITS-1:0]     zero_a;
        logic [ADC_BITS-1:0]     zero_b;
        logic [1:0]              cal_status;
    } scan_reading_t;

    // Block ports
    logic                    aclk       = 1'b0;
    logic                    aresetn    = 1'b0;
    logic                    cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;
    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic                    s_command  = 1'b0;
    logic [ADC_BITS-1:0]     s_code_a   = '0;
    logic [ADC_BITS-1:0]     s_code_b   = '0;
    logic [ADC_BITS-1:0]     s_code_bus = '0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic                    m_sample_valid;
    logic signed [OUT_W-1:0] m_phase_a_ma;
    logic signed [OUT_W-1:0] m_phase_b_ma;
    logic signed [OUT_W-1:0] m_phase_c_ma;
    logic [OUT_W-1:0]        m_bus_mv;
    logic [TOTAL_W-1:0]      m_invalid_total;
    logic [TOTAL_W-1:0]      m_rail_total;
    logic                    m_calibrated;
    logic [ADC_BITS-1:0]     m_zero_code_a;
    logic [ADC_BITS-1:0]     m_zero_code_b;
    logic [1:0]              m_cal_status;

    // Predictor copy of the registers
    logic [CUR_GAIN_W-1:0] gain_cur_q16 = CUR_GAIN_RESET;
    logic [BUS_GAIN_W-1:0] gain_bus_q16 = BUS_GAIN_RESET;
    logic [ADC_BITS-1:0]   bus_floor    = BUS_MIN_RESET;
    logic [ADC_BITS-1:0]   window_lo    = ZERO_MIN_RESET;
    logic [ADC_BITS-1:0]   window_hi    = ZERO_MAX_RESET;
    logic [CNT_W-1:0]      cal_target   = CAL_SAMPLES_RESET;

    // Predictor copy of the block state
    logic [ADC_BITS-1:0] offset_a        = ZERO_RESET;
    logic [ADC_BITS-1:0] offset_b        = ZERO_RESET;
    logic                offsets_trusted = 1'b0;
    longint unsigned     acc_a           = 0;
    longint unsigned     acc_b           = 0;
    logic [CNT_W-1:0]    acc_n           = '0;
    logic [TOTAL_W-1:0]  rejected_scans  = '0;
    logic [TOTAL_W-1:0]  rail_scans      = '0;
    cal_stat_t           last_verdict    = CAL_NONE;

    scan_reading_t readings_due[$];

    bit gaps_on          = 1'b1;
    int hold_reqs        = 0;
    int hold_taken       = 0;
    int hold_left        = 0;
    int quiet_cycles     = 0;
    int mismatches       = 0;
    int readings_checked = 0;
    int scans_offered    = 0;
    int cal_scans        = 0;
    int runs_adopted     = 0;
    int runs_refused     = 0;

    three_phase_current_sense_frontend dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Clamp a floored milliamp value to the signed result range
    function automatic logic signed [OUT_W-1:0] clamp_ma(input longint v);
        if (v > 32767) begin
            return OUT_W'(32767);
        end
        if (v < -32768) begin
            return OUT_W'(-32768);
        end
        return OUT_W'(v);
    endfunction

    // Favour codes close to either rail a quarter of the time
    function automatic logic [ADC_BITS-1:0] rail_biased_code();
        case ($urandom_range(7))
            0: begin
                return ADC_BITS'($urandom_range(70));
            end
            1: begin
                return ADC_BITS'($urandom_range(4095, 4025));
            end
            default: begin
                return ADC_BITS'($urandom_range(4095));
            end
        endcase
    endfunction

    // Set random bits above a 12-bit register now and then; the block must drop them
    function automatic logic [CFG_DATA_W-1:0] pad_upper(input int v);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'(v);
        if ($urandom_range(3) == 0) begin
            w[CFG_DATA_W-1:ADC_BITS] = (CFG_DATA_W - ADC_BITS)'($urandom_range(255, 1));
        end
        return w;
    endfunction

    // Work out the reading one scan produces and advance the predicted state
    task automatic compute_reading(input logic cmd, input logic [ADC_BITS-1:0] a,
                                   input logic [ADC_BITS-1:0] b,
                                   input logic [ADC_BITS-1:0] bus,
                                   output scan_reading_t r);
        longint          cur_a;
        longint          cur_b;
        longint          volts;
        int              goal;
        longint unsigned n;
        longint unsigned avg_a;
        longint unsigned avg_b;
        r = '{default: 0};
        if (cmd == CMD_CONVERT) begin
            if ((a == 0 && b == 0 && bus == 0) || bus < bus_floor) begin
                rejected_scans = rejected_scans + 1'b1;
                if (a < RAIL_LOW_CODE || a > RAIL_HIGH_CODE ||
                    b < RAIL_LOW_CODE || b > RAIL_HIGH_CODE) begin
                    rail_scans = rail_scans + 1'b1;
                end
            end else begin
                cur_a = ((longint'(a) - longint'(offset_a)) * longint'(gain_cur_q16)) >>> Q_FRAC;
                cur_b = ((longint'(b) - longint'(offset_b)) * longint'(gain_cur_q16)) >>> Q_FRAC;
                r.phase_a = clamp_ma(cur_a);
                r.phase_b = clamp_ma(cur_b);
                r.phase_c = clamp_ma(-(longint'(r.phase_a) + longint'(r.phase_b)));
                volts = (longint'(bus) * longint'(gain_bus_q16)) >>> Q_FRAC;
                r.bus_mv = (volts > 65535) ? 16'hFFFF : OUT_W'(volts);
                r.sample_valid = 1'b1;
            end
        end else begin
            // Accumulate; a zero target counts as one scan
            cal_scans++;
            goal = (cal_target == 0) ? 1 : int'(cal_target);
            acc_a += a;
            acc_b += b;
            acc_n = acc_n + 1'b1;
            last_verdict = CAL_NONE;
            if (int'(acc_n) >= goal || acc_n == 0) begin
                n = (acc_n == 0) ? 65536 : acc_n;
                avg_a = acc_a / n;
                avg_b = acc_b / n;
                if (avg_a >= window_lo && avg_a <= window_hi &&
                    avg_b >= window_lo && avg_b <= window_hi) begin
                    offset_a = ADC_BITS'(avg_a);
                    offset_b = ADC_BITS'(avg_b);
                    offsets_trusted = 1'b1;
                    last_verdict = CAL_ACCEPTED;
                    runs_adopted++;
                end else begin
                    offsets_trusted = 1'b0;
                    last_verdict = CAL_REJECTED;
                    runs_refused++;
                end
                acc_a = 0;
                acc_b = 0;
                acc_n = '0;
            end
        end
        r.invalid_total = rejected_scans;
        r.rail_total    = rail_scans;
        r.calibrated    = offsets_trusted;
        r.zero_a        = offset_a;
        r.zero_b        = offset_b;
        r.cal_status    = last_verdict;
    endtask

    // Offer one scan, wait for its handshake and queue the reading it should give
    task automatic offer_scan(input logic cmd, input logic [ADC_BITS-1:0] a,
                              input logic [ADC_BITS-1:0] b,
                              input logic [ADC_BITS-1:0] bus);
        scan_reading_t r;
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (gaps_on && $urandom_range(99) < IDLE_PCT);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_code_a   <= a;
        s_code_b   <= b;
        s_code_bus <= bus;
        do @(posedge aclk); while (!s_ready);
        compute_reading(cmd, a, b, bus, r);
        readings_due.push_back(r);
        scans_offered++;
    endtask

    // Drop valid and wait until every queued reading has come back
    task automatic drain_readings();
        s_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
    endtask

    // Write one register and mirror it in the predictor
    task automatic set_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_CURRENT_GAIN: begin
                gain_cur_q16 = value[CUR_GAIN_W-1:0];
            end
            REG_BUS_GAIN: begin
                gain_bus_q16 = value[BUS_GAIN_W-1:0];
            end
            REG_BUS_MIN: begin
                bus_floor = value[ADC_BITS-1:0];
            end
            REG_ZERO_MIN: begin
                window_lo = value[ADC_BITS-1:0];
            end
            REG_ZERO_MAX: begin
                window_hi = value[ADC_BITS-1:0];
            end
            REG_CAL_SAMPLES: begin
                cal_target = value[CNT_W-1:0];
            end
            default: begin
            end
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic compare_field(input string field, input logic signed [32:0] want,
                                 input logic signed [32:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("reading %0d: %s expected %0d, got %0d",
                         readings_checked, field, want, got);
            end
        end
    endtask

    // Default register values: all-zero scan, bus floor edge and the rail edges
    task automatic check_plausibility_and_rails();
        offer_scan(CMD_CONVERT, 12'd0,    12'd0,    12'd0);
        offer_scan(CMD_CONVERT, 12'd4095, 12'd4095, 12'd4095);
        offer_scan(CMD_CONVERT, 12'd0,    12'd0,    12'd4095);
        offer_scan(CMD_CONVERT, 12'd0,    12'd4095, 12'd200);
        offer_scan(CMD_CONVERT, 12'd2048, 12'd2048, 12'd199);
        offer_scan(CMD_CONVERT, 12'd63,   12'd2048, 12'd100);
        offer_scan(CMD_CONVERT, 12'd64,   12'd4032, 12'd0);
        offer_scan(CMD_CONVERT, 12'd2048, 12'd4033, 12'd5);
    endtask

    // Adopt at the window edges, refuse just outside, interleave converts, zero and inverted setups
    task automatic check_calibration_outcomes();
        drain_readings();
        set_register(REG_CAL_SAMPLES, 20'd2);
        offer_scan(CMD_CALIBRATE, 12'd1241, 12'd2854, 12'd0);
        offer_scan(CMD_CALIBRATE, 12'd1241, 12'd2854, 12'd4095);
        offer_scan(CMD_CONVERT,   12'd2048, 12'd1000, 12'd3000);
        offer_scan(CMD_CALIBRATE, 12'd1240, 12'd2000, 12'd1000);
        offer_scan(CMD_CALIBRATE, 12'd1240, 12'd2000, 12'd1000);
        offer_scan(CMD_CALIBRATE, 12'd2000, 12'd2100, 12'd1000);
        offer_scan(CMD_CONVERT,   12'd3000, 12'd1000, 12'd1000);
        offer_scan(CMD_CALIBRATE, 12'd2002, 12'd2102, 12'd1000);
        drain_readings();
        set_register(REG_CAL_SAMPLES, 20'd0);
        offer_scan(CMD_CALIBRATE, 12'd2855, 12'd2000, 12'd1000);
        drain_readings();
        set_register(REG_ZERO_MIN, 20'd3000);
        set_register(REG_ZERO_MAX, 20'd1000);
        offer_scan(CMD_CALIBRATE, 12'd2048, 12'd2048, 12'd1000);
    endtask

    // Start a long run, then lower the target below the scans already taken
    task automatic check_lowered_sample_target();
        drain_readings();
        set_register(REG_ZERO_MIN, 20'd0);
        set_register(REG_ZERO_MAX, 20'd4095);
        set_register(REG_CAL_SAMPLES, 20'd65535);
        repeat (4) offer_scan(CMD_CALIBRATE, 12'd0, 12'd4095, 12'd2000);
        drain_readings();
        set_register(REG_CAL_SAMPLES, 20'd2);
        offer_scan(CMD_CALIBRATE, 12'd0, 12'd4095, 12'd2000);
    endtask

    // Largest and zero gains against zeros at both rails
    task automatic check_gain_extremes();
        drain_readings();
        set_register(REG_CURRENT_GAIN, 20'd262143);
        set_register(REG_BUS_GAIN, 20'd1048575);
        offer_scan(CMD_CONVERT, 12'd4095, 12'd0,    12'd4095);
        offer_scan(CMD_CONVERT, 12'd0,    12'd4095, 12'd4095);
        drain_readings();
        set_register(REG_CURRENT_GAIN, 20'd0);
        set_register(REG_BUS_GAIN, 20'd0);
        offer_scan(CMD_CONVERT, 12'd4095, 12'd4095, 12'd4095);
    endtask

    // Hold the receiver off while scans keep coming, so the input stalls
    task automatic check_result_backpressure();
        drain_readings();
        set_register(REG_CURRENT_GAIN, 20'(CUR_GAIN_RESET));
        set_register(REG_BUS_GAIN, 20'(BUS_GAIN_RESET));
        set_register(REG_BUS_MIN, 20'(BUS_MIN_RESET));
        hold_reqs++;
        repeat (24) begin
            offer_scan(CMD_CONVERT, ADC_BITS'($urandom), ADC_BITS'($urandom),
                       ADC_BITS'($urandom_range(4095, 200)));
        end
    endtask

    // Phases of random settings, each with mostly well-formed scans plus rejects and noise
    task automatic run_random_traffic(input int phases, input int per_phase);
        int                  pick;
        int                  lo;
        logic [ADC_BITS-1:0] a;
        logic [ADC_BITS-1:0] b;
        logic [ADC_BITS-1:0] bus;
        for (int p = 0; p < phases; p++) begin
            drain_readings();
            case ($urandom_range(7))
                0: begin
                    set_register(REG_CURRENT_GAIN, 20'd0);
                end
                1: begin
                    set_register(REG_CURRENT_GAIN, 20'd262143);
                end
                default: begin
                    set_register(REG_CURRENT_GAIN, 20'($urandom_range(262143)));
                end
            endcase
            case ($urandom_range(7))
                0: begin
                    set_register(REG_BUS_GAIN, 20'd0);
                end
                1: begin
                    set_register(REG_BUS_GAIN, 20'd1048575);
                end
                default: begin
                    set_register(REG_BUS_GAIN, 20'($urandom));
                end
            endcase
            case ($urandom_range(7))
                0: begin
                    set_register(REG_BUS_MIN, pad_upper(0));
                end
                1: begin
                    set_register(REG_BUS_MIN, pad_upper(4095));
                end
                default: begin
                    set_register(REG_BUS_MIN, pad_upper($urandom_range(600)));
                end
            endcase
            case ($urandom_range(9))
                0: begin
                    lo = $urandom_range(4095, 2000);
                    set_register(REG_ZERO_MIN, pad_upper(lo));
                    set_register(REG_ZERO_MAX, pad_upper($urandom_range(lo - 1)));
                end
                1: begin
                    set_register(REG_ZERO_MIN, pad_upper(0));
                    set_register(REG_ZERO_MAX, pad_upper(4095));
                end
                default: begin
                    set_register(REG_ZERO_MIN, pad_upper($urandom_range(1900, 800)));
                    set_register(REG_ZERO_MAX, pad_upper($urandom_range(3300, 2200)));
                end
            endcase
            case ($urandom_range(9))
                0: begin
                    set_register(REG_CAL_SAMPLES, 20'd0);
                end
                1: begin
                    set_register(REG_CAL_SAMPLES, 20'd65535);
                end
                2: begin
                    set_register(REG_CAL_SAMPLES, 20'd1);
                end
                default: begin
                    set_register(REG_CAL_SAMPLES, 20'($urandom_range(12, 2)));
                end
            endcase
            // One phase runs without any idling on either side
            gaps_on = (p != phases / 3);
            for (int i = 0; i < per_phase; i++) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    a   = $urandom_range(1) ? ADC_BITS'($urandom)
                                            : ADC_BITS'($urandom_range(2600, 1500));
                    b   = $urandom_range(1) ? ADC_BITS'($urandom)
                                            : ADC_BITS'($urandom_range(2600, 1500));
                    bus = ADC_BITS'($urandom_range(4095, bus_floor));
                    offer_scan(CMD_CONVERT, a, b, bus);
                end else if (pick < 75) begin
                    a = ($urandom_range(7) == 0) ? rail_biased_code()
                                                 : ADC_BITS'($urandom_range(3000, 1100));
                    b = ($urandom_range(7) == 0) ? rail_biased_code()
                                                 : ADC_BITS'($urandom_range(3000, 1100));
                    offer_scan(CMD_CALIBRATE, a, b, ADC_BITS'($urandom));
                end else if (pick < 90) begin
                    if (bus_floor == 0) begin
                        offer_scan(CMD_CONVERT, 12'd0, 12'd0, 12'd0);
                    end else begin
                        offer_scan(CMD_CONVERT, rail_biased_code(), rail_biased_code(),
                                   ADC_BITS'($urandom_range(bus_floor - 1)));
                    end
                end else begin
                    offer_scan(1'($urandom_range(1)), ADC_BITS'($urandom), ADC_BITS'($urandom),
                               ADC_BITS'($urandom));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_taken != hold_reqs) begin
            hold_taken = hold_reqs;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Compare each result item against the oldest queued reading
    always @(posedge aclk) begin
        scan_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("reading %0d arrived with no scan outstanding", readings_checked);
                end
            end else begin
                want = readings_due.pop_front();
                compare_field("sample_valid",  want.sample_valid,  m_sample_valid);
                compare_field("phase_a_ma",    want.phase_a,       m_phase_a_ma);
                compare_field("phase_b_ma",    want.phase_b,       m_phase_b_ma);
                compare_field("phase_c_ma",    want.phase_c,       m_phase_c_ma);
                compare_field("bus_mv",        want.bus_mv,        m_bus_mv);
                compare_field("invalid_total", want.invalid_total, m_invalid_total);
                compare_field("rail_total",    want.rail_total,    m_rail_total);
                compare_field("calibrated",    want.calibrated,    m_calibrated);
                compare_field("zero_code_a",   want.zero_a,        m_zero_code_a);
                compare_field("zero_code_b",   want.zero_b,        m_zero_code_b);
                compare_field("cal_status",    want.cal_status,    m_cal_status);
            end
            readings_checked++;
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no item moved for %0d cycles, %0d readings outstanding",
                     QUIET_LIMIT, readings_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_plausibility_and_rails();
        check_calibration_outcomes();
        check_lowered_sample_target();
        check_gain_extremes();
        check_result_backpressure();
        run_random_traffic(15, 122);
        drain_readings();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (readings_due.size() != 0) begin
            mismatches += readings_due.size();
            $display("%0d readings never arrived", readings_due.size());
        end
        $display("covered %0d scans (%0d calibration), %0d convert scans rejected, %0d near a rail",
                 scans_offered, cal_scans, rejected_scans, rail_scans);
        $display("calibration runs: %0d adopted, %0d refused; %0d readings checked, %0d mismatches",
                 runs_adopted, runs_refused, readings_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tpcsf_pkg.sv
hdl/tpcsf_div.sv
hdl/tpcsf_ctrl.sv
hdl/tpcsf_dp.sv
hdl/three_phase_current_sense_frontend.sv
hdl/tpcsf_chk.sv
tb/three_phase_current_sense_frontend_tb.sv
